/* hdl/upward_area_ratio_top_defines.svh */
// upward_area_ratio_top_defines.svh: assertion macros for the upward area ratio block.
// Included by uar_seq and upward_area_ratio_top; depends on nothing.
`ifndef UPWARD_AREA_RATIO_TOP_DEFINES_SVH
`define UPWARD_AREA_RATIO_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define UAR_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("upward_area_ratio assertion failed");
`define UAR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("upward_area_ratio assertion failed");
`else
`define UAR_ASSERT(lbl, clk_s, rst_s, prop)
`define UAR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

/* hdl/uar_pkg.sv */
// uar_pkg: widths, sequencer types and the multiply schedule of the upward area ratio block.
// Used by every module of the block; depends on nothing.
package uar_pkg;

  localparam int CoordW = 16;
  localparam int EdgeW  = 17;
  localparam int MulW   = 18;
  localparam int ProdW  = 36;
  localparam int CrossW = 35;
  localparam int MagW   = 34;
  localparam int HalfW  = 17;
  localparam int RadW   = 68;
  localparam int RootW  = 34;
  localparam int SumW   = 52;
  localparam int SubW   = 54;
  localparam int RatioW = 17;
  localparam int ThrW   = 15;
  localparam int StepW  = 6;
  localparam int CompW  = 2;

  localparam logic [ThrW-1:0]  THRESH_RESET = 15'd11469;
  localparam logic [StepW-1:0] MUL_LAST  = 6'd15;
  localparam logic [StepW-1:0] ROOT_LAST = 6'd33;
  localparam logic [StepW-1:0] DIV_LAST  = 6'd16;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_ROOT = 6'b000100,
    ST_ACC  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  typedef struct packed {
    state_t           state;
    logic [StepW-1:0] step;
    logic             accept;
    logic             out_load;
  } ctrl_t;

  typedef enum logic [2:0] {
    OP_UX, OP_UY, OP_UZ, OP_VX, OP_VY, OP_VZ, OP_HI, OP_LO
  } mul_op_t;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_SET, ACT_SUB, ACT_SQ_HI, ACT_SQ_MID, ACT_SQ_LO
  } acc_act_t;

  typedef struct packed {
    mul_op_t          op_a;
    mul_op_t          op_b;
    logic [CompW-1:0] comp;
  } mul_plan_t;

  typedef struct packed {
    acc_act_t         act;
    logic [CompW-1:0] comp;
  } acc_plan_t;

  // operands issued to the multiplier at each step of the multiply phase
  function automatic mul_plan_t issue_plan(input logic [StepW-1:0] step);
    mul_plan_t p;
    p = '{op_a: OP_UX, op_b: OP_UX, comp: 2'd0};
    unique case (step)
      6'd0:  p = '{op_a: OP_UY, op_b: OP_VZ, comp: 2'd0};
      6'd1:  p = '{op_a: OP_UZ, op_b: OP_VY, comp: 2'd0};
      6'd2:  p = '{op_a: OP_UZ, op_b: OP_VX, comp: 2'd0};
      6'd3:  p = '{op_a: OP_UX, op_b: OP_VZ, comp: 2'd0};
      6'd4:  p = '{op_a: OP_UX, op_b: OP_VY, comp: 2'd0};
      6'd5:  p = '{op_a: OP_UY, op_b: OP_VX, comp: 2'd0};
      6'd6:  p = '{op_a: OP_HI, op_b: OP_HI, comp: 2'd0};
      6'd7:  p = '{op_a: OP_HI, op_b: OP_LO, comp: 2'd0};
      6'd8:  p = '{op_a: OP_LO, op_b: OP_LO, comp: 2'd0};
      6'd9:  p = '{op_a: OP_HI, op_b: OP_HI, comp: 2'd1};
      6'd10: p = '{op_a: OP_HI, op_b: OP_LO, comp: 2'd1};
      6'd11: p = '{op_a: OP_LO, op_b: OP_LO, comp: 2'd1};
      6'd12: p = '{op_a: OP_HI, op_b: OP_HI, comp: 2'd2};
      6'd13: p = '{op_a: OP_HI, op_b: OP_LO, comp: 2'd2};
      6'd14: p = '{op_a: OP_LO, op_b: OP_LO, comp: 2'd2};
      default: p = '{op_a: OP_UX, op_b: OP_UX, comp: 2'd0};
    endcase
    return p;
  endfunction

  // use of the product issued one step earlier
  function automatic acc_plan_t consume_plan(input logic [StepW-1:0] step);
    acc_plan_t p;
    p = '{act: ACT_NONE, comp: 2'd0};
    unique case (step)
      6'd1:  p = '{act: ACT_SET,    comp: 2'd0};
      6'd2:  p = '{act: ACT_SUB,    comp: 2'd0};
      6'd3:  p = '{act: ACT_SET,    comp: 2'd1};
      6'd4:  p = '{act: ACT_SUB,    comp: 2'd1};
      6'd5:  p = '{act: ACT_SET,    comp: 2'd2};
      6'd6:  p = '{act: ACT_SUB,    comp: 2'd2};
      6'd7:  p = '{act: ACT_SQ_HI,  comp: 2'd0};
      6'd8:  p = '{act: ACT_SQ_MID, comp: 2'd0};
      6'd9:  p = '{act: ACT_SQ_LO,  comp: 2'd0};
      6'd10: p = '{act: ACT_SQ_HI,  comp: 2'd1};
      6'd11: p = '{act: ACT_SQ_MID, comp: 2'd1};
      6'd12: p = '{act: ACT_SQ_LO,  comp: 2'd1};
      6'd13: p = '{act: ACT_SQ_HI,  comp: 2'd2};
      6'd14: p = '{act: ACT_SQ_MID, comp: 2'd2};
      6'd15: p = '{act: ACT_SQ_LO,  comp: 2'd2};
      default: p = '{act: ACT_NONE, comp: 2'd0};
    endcase
    return p;
  endfunction

endpackage

/* hdl/uar_mul.sv */
// uar_mul: shared signed 18x18 multiplier with a registered product.
// Depends on uar_pkg.
module uar_mul
  import uar_pkg::*;
(
  input  logic                    clk,
  input  logic signed [MulW-1:0]  a,
  input  logic signed [MulW-1:0]  b,
  output logic signed [ProdW-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

/* hdl/uar_cmpsub.sv */
// uar_cmpsub: shared compare-and-subtract step for the square root and the ratio divide.
// Depends on uar_pkg.
module uar_cmpsub
  import uar_pkg::*;
(
  input  logic [SubW-1:0] a,
  input  logic [SubW-1:0] b,
  output logic            ge,
  output logic [SubW-1:0] diff
);

  logic [SubW:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign ge   = ~wide[SubW];
  assign diff = wide[SubW-1:0];

endmodule

/* hdl/uar_seq.sv */
// uar_seq: steps a triangle through multiply, root, sum; last adds divide, output.
// Depends on uar_pkg and upward_area_ratio_top_defines.svh.
`include "upward_area_ratio_top_defines.svh"

module uar_seq
  import uar_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  last_face,
  input  logic  out_free,
  output ctrl_t ctrl
);

  state_t           state, state_next;
  logic [StepW-1:0] step, step_next;
  logic             last;
  logic             accept;

  assign accept = (state == ST_IDLE) && in_valid;

  always_comb begin
    state_next = state;
    step_next  = step + 1'b1;
    unique case (state)
      ST_IDLE: begin
        step_next = '0;
        if (in_valid) state_next = ST_MUL;
      end
      ST_MUL: begin
        if (step == MUL_LAST) begin
          state_next = ST_ROOT;
          step_next  = '0;
        end
      end
      ST_ROOT: begin
        if (step == ROOT_LAST) begin
          state_next = ST_ACC;
          step_next  = '0;
        end
      end
      ST_ACC: begin
        step_next  = '0;
        state_next = last ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (step == DIV_LAST) begin
          state_next = ST_OUT;
          step_next  = '0;
        end
      end
      ST_OUT: begin
        step_next = '0;
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
        step_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      last  <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (accept) last <= last_face;
    end
  end

  assign ctrl.state    = state;
  assign ctrl.step     = step;
  assign ctrl.accept   = accept;
  assign ctrl.out_load = (state == ST_OUT) && out_free;

  `UAR_ASSERT_NEXT(a_accept_starts_mul, clk, rst, accept, state == ST_MUL && step == '0)
  `UAR_ASSERT(a_load_only_on_last, clk, rst, ctrl.out_load |-> last)

endmodule

/* hdl/upward_area_ratio_top.sv */
// upward_area_ratio_top: triangle area accumulation and usable-area ratio, top level.
// Depends on uar_pkg, uar_mul, uar_cmpsub, uar_seq and upward_area_ratio_top_defines.svh.
//
//   channel  | handshake            | fields
//   ---------+----------------------+-----------------------------------------------
//   in       | in_valid / in_ready  | ax ay az bx by_coord bz cx cy cz normal_z last_face
//   out      | out_valid / out_ready| ratio empty_mesh
//   cfg      | cfg_we               | cfg_wdata (slope_threshold)
//
// Ready drops at an accept and returns only when the triangle is done, so triangles do not overlap:
// the shared 18x18 multiplier forms the cross product, then its squares in 17-bit halves;
// the shared compare-subtract unit takes the square root; then the sums are updated.
// A last triangle adds a divide on the same compare-subtract unit and one output load.
// Reset is synchronous; the sums clear to zero and the threshold returns to 11469.
// A held output word stalls only a last triangle, which waits before loading its result.
`include "upward_area_ratio_top_defines.svh"

module upward_area_ratio_top
  import uar_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [ThrW-1:0]          cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [CoordW-1:0] ax,
  input  logic signed [CoordW-1:0] ay,
  input  logic signed [CoordW-1:0] az,
  input  logic signed [CoordW-1:0] bx,
  input  logic signed [CoordW-1:0] by_coord,
  input  logic signed [CoordW-1:0] bz,
  input  logic signed [CoordW-1:0] cx,
  input  logic signed [CoordW-1:0] cy,
  input  logic signed [CoordW-1:0] cz,
  input  logic signed [CoordW-1:0] normal_z,
  input  logic                     last_face,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [RatioW-1:0]        ratio,
  output logic                     empty_mesh
);

  ctrl_t ctrl;
  logic  out_free;

  logic [ThrW-1:0] slope_threshold;

  logic signed [EdgeW-1:0]  ux, uy, uz, vx, vy, vz;
  logic                     usable;
  logic signed [ProdW-1:0]  kacc;
  logic signed [CrossW-1:0] kc [3];
  logic [RadW-1:0]          rad;
  logic [SubW-1:0]          rem;
  logic [RootW-1:0]         qr;
  logic [SumW-1:0]          total_sum, usable_sum;

  mul_plan_t                iplan;
  acc_plan_t                cplan;
  logic signed [CrossW-1:0] k_sel;
  logic [CrossW-1:0]        k_abs;
  logic [MagW-1:0]          mag;
  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [ProdW-1:0]  prod;
  logic [MagW-1:0]          sq;

  logic [SubW-1:0] cs_a, cs_b, cs_diff;
  logic            cs_ge;

  logic [SumW:0]   total_add, usable_add;

  uar_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_face (last_face),
    .out_free  (out_free),
    .ctrl      (ctrl)
  );

  assign in_ready = (ctrl.state == ST_IDLE);
  assign out_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slope_threshold <= THRESH_RESET;
    end else if (cfg_we) begin
      slope_threshold <= cfg_wdata;
    end
  end

  // multiplier operand selection
  assign iplan = issue_plan(ctrl.step);
  assign cplan = consume_plan(ctrl.step);
  assign k_sel = kc[iplan.comp];
  assign k_abs = k_sel[CrossW-1] ? $unsigned(-k_sel) : $unsigned(k_sel);
  assign mag   = k_abs[MagW-1:0];

  always_comb begin
    case (iplan.op_a)
      OP_UX:   mul_a = {ux[EdgeW-1], ux};
      OP_UY:   mul_a = {uy[EdgeW-1], uy};
      OP_UZ:   mul_a = {uz[EdgeW-1], uz};
      OP_VX:   mul_a = {vx[EdgeW-1], vx};
      OP_VY:   mul_a = {vy[EdgeW-1], vy};
      OP_VZ:   mul_a = {vz[EdgeW-1], vz};
      OP_HI:   mul_a = {1'b0, mag[MagW-1:HalfW]};
      OP_LO:   mul_a = {1'b0, mag[HalfW-1:0]};
      default: mul_a = '0;
    endcase
    case (iplan.op_b)
      OP_UX:   mul_b = {ux[EdgeW-1], ux};
      OP_UY:   mul_b = {uy[EdgeW-1], uy};
      OP_UZ:   mul_b = {uz[EdgeW-1], uz};
      OP_VX:   mul_b = {vx[EdgeW-1], vx};
      OP_VY:   mul_b = {vy[EdgeW-1], vy};
      OP_VZ:   mul_b = {vz[EdgeW-1], vz};
      OP_HI:   mul_b = {1'b0, mag[MagW-1:HalfW]};
      OP_LO:   mul_b = {1'b0, mag[HalfW-1:0]};
      default: mul_b = '0;
    endcase
  end

  uar_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign sq = prod[MagW-1:0];

  // shared compare-subtract: root step or divide step
  always_comb begin
    if (ctrl.state == ST_ROOT) begin
      cs_a = {17'b0, rem[34:0], rad[RadW-1:RadW-2]};
      cs_b = {18'b0, qr, 2'b01};
    end else if (ctrl.step == '0) begin
      cs_a = {2'b0, usable_sum};
      cs_b = {2'b0, total_sum};
    end else begin
      cs_a = {rem[SubW-2:0], 1'b0};
      cs_b = {2'b0, total_sum};
    end
  end

  uar_cmpsub u_cmpsub (
    .a    (cs_a),
    .b    (cs_b),
    .ge   (cs_ge),
    .diff (cs_diff)
  );

  assign total_add  = {1'b0, total_sum}  + {{(SumW+1-RootW){1'b0}}, qr};
  assign usable_add = {1'b0, usable_sum} + {{(SumW+1-RootW){1'b0}}, qr};

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      ux     <= {cx[CoordW-1], cx} - {ax[CoordW-1], ax};
      uy     <= {cy[CoordW-1], cy} - {ay[CoordW-1], ay};
      uz     <= {cz[CoordW-1], cz} - {az[CoordW-1], az};
      vx     <= {bx[CoordW-1], bx} - {ax[CoordW-1], ax};
      vy     <= {by_coord[CoordW-1], by_coord} - {ay[CoordW-1], ay};
      vz     <= {bz[CoordW-1], bz} - {az[CoordW-1], az};
      usable <= normal_z > $signed({1'b0, slope_threshold});
      rad    <= '0;
      rem    <= '0;
      qr     <= '0;
    end else begin
      unique case (ctrl.state)
        ST_MUL: begin
          case (cplan.act)
            ACT_SET:    kacc <= prod;
            ACT_SUB:    kc[cplan.comp] <= CrossW'(kacc - prod);
            ACT_SQ_HI:  rad <= rad + {sq, 34'b0};
            ACT_SQ_MID: rad <= rad + {16'b0, sq, 18'b0};
            ACT_SQ_LO:  rad <= rad + {34'b0, sq};
            default:    ;
          endcase
        end
        ST_ROOT: begin
          rad <= {rad[RadW-3:0], 2'b00};
          rem <= cs_ge ? cs_diff : cs_a;
          qr  <= {qr[RootW-2:0], cs_ge};
        end
        ST_ACC: begin
          rem <= '0;
          qr  <= '0;
        end
        ST_DIV: begin
          rem <= cs_ge ? cs_diff : cs_a;
          qr  <= {qr[RootW-2:0], cs_ge};
        end
        default: ;
      endcase
    end
  end

  // area sums, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      total_sum  <= '0;
      usable_sum <= '0;
    end else if (ctrl.out_load) begin
      total_sum  <= '0;
      usable_sum <= '0;
    end else if (ctrl.state == ST_ACC) begin
      total_sum <= total_add[SumW] ? '1 : total_add[SumW-1:0];
      if (usable) usable_sum <= usable_add[SumW] ? '1 : usable_add[SumW-1:0];
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      empty_mesh <= (total_sum == '0);
      ratio      <= (total_sum == '0) ? '0 : qr[RatioW-1:0];
    end
  end

  `UAR_ASSERT(a_usable_within_total, clk, rst, usable_sum <= total_sum)
  `UAR_ASSERT(a_root_rem_bound, clk, rst, ctrl.state == ST_ROOT |-> rem[SubW-1:35] == '0)
  `UAR_ASSERT(a_empty_gives_zero, clk, rst, out_valid && empty_mesh |-> ratio == '0)
  `UAR_ASSERT(a_ratio_at_most_one, clk, rst, out_valid && ratio[RatioW-1] |-> ratio[RatioW-2:0] == '0)

endmodule
